[hw/rtl/drs_pkg.sv]
`timescale 1ns / 1ps

package drs_pkg;

    localparam int unsigned COORD_W  = 15;   // clamped coordinate / length width
    localparam int unsigned POS_W    = 17;   // run position width
    localparam int unsigned QUO_W    = 15;   // divider quotient width
    localparam int unsigned DVS_W    = 6;    // divider divisor width
    localparam int unsigned CNT_W    = 6;    // dash count width
    localparam int unsigned PITCH_W  = 12;   // dash pitch width
    localparam int unsigned RECIP_W  = 16;   // reciprocal of the dash period
    localparam int unsigned RECIP_SH = 21;
    localparam int unsigned PROD_W   = COORD_W + RECIP_W;
    localparam int unsigned NQ_W     = PROD_W - RECIP_SH;

    localparam logic [COORD_W-1:0] MAX_LENGTH   = 15'd3839;
    localparam logic [COORD_W-1:0] BLACK_DASH   = 15'd40;
    localparam logic [COORD_W-1:0] DASH_PERIOD  = 15'd60;
    // ceil(2^21 / 60); exact floor(len / 60) for any 15-bit length
    localparam logic [RECIP_W-1:0] RECIP_PERIOD = 16'd34953;
    localparam logic [CNT_W-1:0]   DASH_CAP     = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_S_GO,
        ST_DIV_S,
        ST_EMIT_FIRST,
        ST_EMIT_DASH
    } drs_state_t;

    typedef struct packed {
        logic         load;
        logic         div_start;
        logic         cap_n;
        logic         cap_s;
        logic         emit_first;
        logic         emit_dash;
    } drs_cmd_t;

    typedef struct packed {
        logic single;
        logic div_done;
        logic out_free;
        logic last_dash;
    } drs_status_t;

endpackage

[hw/rtl/drs_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module drs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [drs_pkg::QUO_W-1:0]  dividend,
    input  logic [drs_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [drs_pkg::QUO_W-1:0]  quotient,
    output logic [drs_pkg::DVS_W-1:0]  remainder
);
    import drs_pkg::*;

    localparam int unsigned STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [STEP_W-1:0]   cnt_reg,   cnt_next;
    logic [QUO_W-1:0]    quo_reg,   quo_next;
    logic [DVS_W-1:0]    rem_reg,   rem_next;
    logic [DVS_W-1:0]    dvs_reg,   dvs_next;

    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      diff;
    logic                ge;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[QUO_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/drs_datapath.sv]
`timescale 1ns / 1ps

module drs_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  drs_pkg::drs_cmd_t     cmd,
    output drs_pkg::drs_status_t  status,
    input  logic [63:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,
    output logic                  m_tlast
);
    import drs_pkg::*;

    logic [COORD_W-1:0] x_reg,     x_next;
    logic [COORD_W-1:0] y_reg,     y_next;
    logic [COORD_W-1:0] len_reg,   len_next;
    logic [COORD_W-1:0] thick_reg, thick_next;
    logic               dashed_reg, dashed_next;
    logic               vert_reg,  vert_next;
    logic [CNT_W-1:0]   n_reg,     n_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic [DVS_W-1:0]   rem_reg,   rem_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;

    logic               mvalid_reg, mvalid_next;
    logic [63:0]        mdata_reg,  mdata_next;
    logic               mlast_reg,  mlast_next;

    logic [COORD_W-1:0] in_x, in_y, in_len_c, in_len;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [DVS_W-1:0]   div_rem;
    logic [QUO_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [PROD_W-1:0]  n_prod;
    logic [NQ_W-1:0]    n_quo;
    logic               single;
    logic               out_free;
    logic [COORD_W-1:0] seg_len;
    logic [15:0]        seg_x, seg_y;
    logic [14:0]        seg_h, seg_w;

    // negative fields clamp to zero
    assign in_x     = s_tdata[15] ? '0 : s_tdata[14:0];
    assign in_y     = s_tdata[31] ? '0 : s_tdata[30:16];
    assign in_len_c = s_tdata[47] ? '0 : s_tdata[46:32];
    assign in_len   = (in_len_c > MAX_LENGTH) ? MAX_LENGTH : in_len_c;

    assign single   = !dashed_reg || (len_reg < DASH_PERIOD);
    assign out_free = !mvalid_reg || m_tready;

    // dash count = length / 60 by reciprocal multiply
    assign n_prod = PROD_W'(len_reg) * PROD_W'(RECIP_PERIOD);
    assign n_quo  = n_prod[PROD_W-1:RECIP_SH];

    assign div_dividend = len_reg - BLACK_DASH;
    assign div_divisor  = n_reg;

    drs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign seg_len = cmd.emit_dash ? BLACK_DASH
                   : (single ? len_reg : (COORD_W'(rem_reg) + BLACK_DASH));

    always_comb begin
        if (vert_reg) begin
            seg_x = {1'b0, x_reg};
            seg_y = pos_reg[15:0];
            seg_h = seg_len;
            seg_w = thick_reg;
        end else begin
            seg_x = pos_reg[15:0];
            seg_y = {1'b0, y_reg};
            seg_h = thick_reg;
            seg_w = seg_len;
        end
    end

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        len_next    = len_reg;
        thick_next  = thick_reg;
        dashed_next = dashed_reg;
        vert_next   = vert_reg;
        n_next      = n_reg;
        pitch_next  = pitch_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;

        if (cmd.load) begin
            x_next      = in_x;
            y_next      = in_y;
            len_next    = in_len;
            thick_next  = s_tdata[62:48];
            dashed_next = s_tuser[0];
            vert_next   = s_tuser[1];
            pos_next    = POS_W'(s_tuser[1] ? in_y : in_x);
        end

        if (cmd.cap_n) begin
            n_next = (n_quo > NQ_W'(DASH_CAP)) ? DASH_CAP : n_quo[CNT_W-1:0];
        end

        if (cmd.cap_s) begin
            pitch_next = div_quo[PITCH_W-1:0];
            rem_next   = div_rem;
        end

        if (m_tready) begin
            mvalid_next = 1'b0;
        end

        if (cmd.emit_first || cmd.emit_dash) begin
            mvalid_next = 1'b1;
            mdata_next  = {2'b00, seg_w, seg_h, seg_y, seg_x};
        end

        if (cmd.emit_first) begin
            mlast_next = single;
            // first 40-dot dash starts at start + first + s - 40 = start + rem + s
            pos_next   = pos_reg + POS_W'(rem_reg) + POS_W'(pitch_reg);
        end

        if (cmd.emit_dash) begin
            mlast_next = (n_reg == CNT_W'(1));
            pos_next   = pos_reg + POS_W'(pitch_reg);
            n_next     = n_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
            n_reg      <= '0;
            pitch_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            mvalid_reg <= mvalid_next;
            n_reg      <= n_next;
            pitch_reg  <= pitch_next;
            pos_reg    <= pos_next;
        end
        x_reg      <= x_next;
        y_reg      <= y_next;
        len_reg    <= len_next;
        thick_reg  <= thick_next;
        dashed_reg <= dashed_next;
        vert_reg   <= vert_next;
        rem_reg    <= rem_next;
        mdata_reg  <= mdata_next;
        mlast_reg  <= mlast_next;
    end

    assign status.single    = single;
    assign status.div_done  = div_done;
    assign status.out_free  = out_free;
    assign status.last_dash = (n_reg == CNT_W'(1));

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

[hw/rtl/drs_ctrl.sv]
`timescale 1ns / 1ps

module drs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  drs_pkg::drs_status_t  status,
    output drs_pkg::drs_cmd_t     cmd
);
    import drs_pkg::*;

    drs_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.single ? ST_EMIT_FIRST : ST_DIV_S_GO;
            end
            ST_DIV_S_GO: begin
                state_next = ST_DIV_S;
            end
            ST_DIV_S: begin
                if (status.div_done) state_next = ST_EMIT_FIRST;
            end
            ST_EMIT_FIRST: begin
                if (status.out_free) state_next = status.single ? ST_IDLE : ST_EMIT_DASH;
            end
            ST_EMIT_DASH: begin
                if (status.out_free && status.last_dash) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK: begin
                cmd.cap_n = !status.single;
            end
            ST_DIV_S_GO: begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_S: begin
                cmd.cap_s = status.div_done;
            end
            ST_EMIT_FIRST: begin
                cmd.emit_first = status.out_free;
            end
            ST_EMIT_DASH: begin
                cmd.emit_dash = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/dashed_rule_splitter.sv]
`timescale 1ns / 1ps
// A solid or short line gives a single rectangle.
// A dashed line gets its dash count by a reciprocal multiply, then runs one serial
// divide for the pitch; its first rectangle follows the divide, then one rectangle per cycle
// while the output is not stalled (n+1 in all, n <= 63).
// Lines are taken one at a time: the next line is accepted only after the last rectangle
// of the current line has been loaded into the output register.
// Reset: synchronous, active low; returns to idle with no result pending.
module dashed_rule_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // start_x[15:0], start_y[31:16], line_length[47:32],
                                   // thickness[62:48], zero[63]
    input  logic [1:0]  s_tuser,   // is_dashed[0], is_vertical[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // seg_x[15:0], seg_y[31:16], seg_height[46:32],
                                   // seg_width[61:47], zero[63:62]
    output logic        m_tlast
);
    import drs_pkg::*;

    drs_cmd_t    cmd;
    drs_status_t status;

    drs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drs_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/drs_rect_checker.sv]
`timescale 1ns / 1ps

module drs_rect_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          outstanding
);

    import drs_pkg::MAX_LENGTH;
    import drs_pkg::BLACK_DASH;
    import drs_pkg::DASH_PERIOD;
    import drs_pkg::DASH_CAP;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] height;
        logic [14:0] width;
        logic        last;
    } rect_t;

    rect_t pending_rects[$];
    rect_t got_rect;
    rect_t want_rect;

    function automatic void push_rect(input logic vert, input logic [14:0] fixed_c,
                                      input logic [16:0] pos, input int unsigned len,
                                      input logic [14:0] thick, input logic last);
        rect_t r;
        if (vert) begin
            r.x      = {1'b0, fixed_c};
            r.y      = pos[15:0];
            r.height = 15'(len);
            r.width  = thick;
        end else begin
            r.x      = pos[15:0];
            r.y      = {1'b0, fixed_c};
            r.height = thick;
            r.width  = 15'(len);
        end
        r.last = last;
        pending_rects.push_back(r);
    endfunction

    // Expand one line request into the rectangles the splitter should emit.
    function automatic void split_line(input logic [63:0] data, input logic [1:0] user);
        logic [14:0] x, y, len, thick, fixed_c;
        logic [16:0] pos;
        logic        dashed, vert;
        int unsigned n, pitch, first_len, k;
        x      = data[15] ? 15'd0 : data[14:0];
        y      = data[31] ? 15'd0 : data[30:16];
        len    = data[47] ? 15'd0 : data[46:32];
        thick  = data[62:48];
        dashed = user[0];
        vert   = user[1];
        if (len > MAX_LENGTH)
            len = MAX_LENGTH;
        fixed_c = vert ? x : y;
        pos     = vert ? {2'b00, y} : {2'b00, x};
        n = len / DASH_PERIOD;
        if (n > DASH_CAP)
            n = DASH_CAP;
        if (!dashed || n == 0) begin
            push_rect(vert, fixed_c, pos, len, thick, 1'b1);
            return;
        end
        pitch     = (len - BLACK_DASH) / n;
        first_len = len - n * pitch;
        push_rect(vert, fixed_c, pos, first_len, thick, 1'b0);
        pos = 17'(pos + first_len + pitch - BLACK_DASH);
        for (k = n; k >= 1; k--) begin
            push_rect(vert, fixed_c, pos, BLACK_DASH, thick, k == 1);
            pos = 17'(pos + pitch);
        end
    endfunction

    function automatic void report_mismatch(input string field, input int unsigned want,
                                            input int unsigned got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, want, got);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                split_line(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got_rect.x      = m_tdata[15:0];
                got_rect.y      = m_tdata[31:16];
                got_rect.height = m_tdata[46:32];
                got_rect.width  = m_tdata[61:47];
                got_rect.last   = m_tlast;
                if (pending_rects.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected rectangle x=%0d y=%0d h=%0d w=%0d last=%0d",
                                 $realtime, got_rect.x, got_rect.y, got_rect.height,
                                 got_rect.width, got_rect.last);
                end else begin
                    want_rect = pending_rects.pop_front();
                    if (got_rect.x != want_rect.x)
                        report_mismatch("seg_x", want_rect.x, got_rect.x);
                    if (got_rect.y != want_rect.y)
                        report_mismatch("seg_y", want_rect.y, got_rect.y);
                    if (got_rect.height != want_rect.height)
                        report_mismatch("seg_height", want_rect.height, got_rect.height);
                    if (got_rect.width != want_rect.width)
                        report_mismatch("seg_width", want_rect.width, got_rect.width);
                    if (got_rect.last != want_rect.last)
                        report_mismatch("seg_last", want_rect.last, got_rect.last);
                end
            end
        end
        outstanding = pending_rects.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_ITEMS = 34;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    int errors;
    int outstanding;
    int cycles = 0;
    int src_idle_pct = 23;
    int sink_idle_pct = 80;

    dashed_rule_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    drs_rect_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Entered and left at a falling edge; tvalid stays high between back-to-back beats.
    task automatic send_line(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] len, input logic [14:0] thick,
                             input logic dashed, input logic vert);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {1'b0, thick, len, y, x};
        s_tuser  <= {vert, dashed};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(32767));
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(59));
            2:       return 16'($urandom_range(200, 60));
            3:       return 16'($urandom_range(3839, 3780));
            default: return 16'($urandom_range(3839));
        endcase
    endfunction

    task automatic send_random_lines(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_line(pick_coord(), pick_coord(), pick_length(), 15'($urandom),
                      $urandom_range(9) < 8, 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero length, short dashed, overlapping dashes (n = 1, short remainder)
        send_line(16'd0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0);
        send_line(16'd5, 16'd7, 16'd0, 15'd3, 1'b1, 1'b1);
        send_line(16'd100, 16'd200, 16'd59, 15'd4, 1'b1, 1'b1);
        send_line(16'd10, 16'd20, 16'd60, 15'd2, 1'b1, 1'b0);
        send_line(16'd30, 16'd40, 16'd70, 15'd6, 1'b1, 1'b1);
        send_line(16'd1, 16'd2, 16'd119, 15'd1, 1'b1, 1'b0);
        send_line(16'd3, 16'd4, 16'd120, 15'd8, 1'b1, 1'b1);
        send_line(16'd179, 16'd9, 16'd179, 15'd1, 1'b1, 1'b0);
        // full length and saturation, at the coordinate maximum
        send_line(16'h7FFF, 16'h7FFF, 16'd3839, 15'h7FFF, 1'b1, 1'b1);
        send_line(16'h7FFF, 16'h7FFF, 16'd3840, 15'h7FFF, 1'b1, 1'b0);
        send_line(16'd50, 16'd60, 16'h7FFF, 15'd12, 1'b1, 1'b0);
        send_line(16'd50, 16'd60, 16'd3780, 15'd12, 1'b1, 1'b1);
        send_line(16'd11, 16'd22, 16'd5000, 15'd9, 1'b0, 1'b0);
        // negative inputs clamp to zero
        send_line(16'd11, 16'd22, 16'hFFFF, 15'd9, 1'b1, 1'b0);
        send_line(16'd11, 16'd22, 16'h8000, 15'd9, 1'b0, 1'b1);
        send_line(16'hFFFF, 16'h8000, 16'd3839, 15'h7FFF, 1'b0, 1'b1);
        send_line(16'h8000, 16'hFFFF, 16'd1000, 15'd0, 1'b1, 1'b1);
        send_line(16'h5555, 16'h2AAA, 16'd1, 15'h2AAA, 1'b0, 1'b1);

        send_random_lines(PHASE_ITEMS);
        src_idle_pct  = 80;
        sink_idle_pct = 23;
        send_random_lines(PHASE_ITEMS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_lines(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
